// File: design/gap_pkg.sv
package gap_pkg;

  localparam int GRID_COLS_DEF = 8;
  localparam int GRID_ROWS_DEF = 8;
  localparam int MAX_RESULTS   = 64;
  localparam int COORD_W       = 3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic init;
    logic scan_clr;
    logic scan;
    logic walk_init;
    logic out_none;
    logic exp;
    logic exp2;
    logic nb;
    logic nbu;
    logic walk;
    logic walk2;
    logic erd;
    logic emit;
  } gap_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_search;
    logic in_bad;
    logic in_same;
    logic scan_last;
    logic any;
    logic cur_goal;
    logic nb_ok;
    logic dir_last;
    logic has_par;
    logic emit_last;
  } gap_sts_t;

endpackage

// File: design/grid_astar_path_search.sv
// Grid A* path search over a GRID_COLS x GRID_ROWS map of wall bits.
// Input channel: an item is taken at a clock edge with start high and busy
// low. in_operation 0 writes one wall bit; 1 searches from start to goal
// with 4-neighbor moves and a Manhattan estimate.
// Result channel: each result item shows on the out_ ports for one cycle,
// marked by out_valid; the receiver must take it, it cannot stall.
// A wall write, a search with start equal to goal, or a search with a
// coordinate off the grid answers with one item in the cycle after it is
// taken, and busy stays low, so such items can follow back to back.
// A full search runs as: an init state, then per expansion a linear best-f
// scan over the estimate store (one cell a cycle, N = GRID_COLS*GRID_ROWS),
// a cost fetch (EXP, EXP2), and an NB check per neighbor plus an NBU update
// for each neighbor that can be entered; then WALK and WALK2 per path step to
// walk parents back from the goal, and ERD and EMIT per emitted step. The scan
// loop dominates the run time; busy is high throughout.
// Reset: all cells open, no search state, busy low, no result pending.
module grid_astar_path_search #(
  parameter int GRID_COLS = gap_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = gap_pkg::GRID_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_operation,
  input  logic [2:0] in_cell_col,
  input  logic [2:0] in_cell_row,
  input  logic       in_cell_wall,
  input  logic [2:0] in_start_col,
  input  logic [2:0] in_start_row,
  input  logic [2:0] in_goal_col,
  input  logic [2:0] in_goal_row,
  output logic       out_valid,
  output logic [2:0] out_step_col,
  output logic [2:0] out_step_row,
  output logic       out_found,
  output logic       out_empty_path,
  output logic       out_last
);

  gap_pkg::gap_cmd_t cmd;
  gap_pkg::gap_sts_t sts;

  // sequence the search: scan, expand, walk back, emit
  gap_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // hold the map, per-cell search stores and the result register
  gap_dp #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_operation   (in_operation),
    .in_cell_col    (in_cell_col),
    .in_cell_row    (in_cell_row),
    .in_cell_wall   (in_cell_wall),
    .in_start_col   (in_start_col),
    .in_start_row   (in_start_row),
    .in_goal_col    (in_goal_col),
    .in_goal_row    (in_goal_row),
    .out_valid      (out_valid),
    .out_step_col   (out_step_col),
    .out_step_row   (out_step_row),
    .out_found      (out_found),
    .out_empty_path (out_empty_path),
    .out_last       (out_last)
  );

endmodule

// File: design/gap_ctrl.sv
module gap_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  gap_pkg::gap_sts_t sts,
  output gap_pkg::gap_cmd_t cmd,
  output logic              busy
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_INIT   = 13'b0000000000010,
    S_SCAN   = 13'b0000000000100,
    S_TAIL   = 13'b0000000001000,
    S_DECIDE = 13'b0000000010000,
    S_EXP    = 13'b0000000100000,
    S_EXP2   = 13'b0000001000000,
    S_NB     = 13'b0000010000000,
    S_NBU    = 13'b0000100000000,
    S_WALK   = 13'b0001000000000,
    S_WALK2  = 13'b0010000000000,
    S_ERD    = 13'b0100000000000,
    S_EMIT   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (sts.is_search && !sts.in_bad && !sts.in_same) state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init     = 1'b1;
        cmd.scan_clr = 1'b1;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_TAIL;
      end
      S_TAIL: state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (!sts.any) begin
          cmd.out_none = 1'b1;
          state_nxt    = S_IDLE;
        end else if (sts.cur_goal) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK;
        end else begin
          state_nxt = S_EXP;
        end
      end
      S_EXP: begin
        cmd.exp   = 1'b1;
        state_nxt = S_EXP2;
      end
      S_EXP2: begin
        cmd.exp2  = 1'b1;
        state_nxt = S_NB;
      end
      S_NB: begin
        cmd.nb = 1'b1;
        if (sts.nb_ok) begin
          state_nxt = S_NBU;
        end else if (sts.dir_last) begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_NBU: begin
        cmd.nbu = 1'b1;
        if (sts.dir_last) begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_SCAN;
        end else begin
          state_nxt = S_NB;
        end
      end
      S_WALK: begin
        cmd.walk  = 1'b1;
        state_nxt = sts.has_par ? S_WALK2 : S_ERD;
      end
      S_WALK2: begin
        cmd.walk2 = 1'b1;
        state_nxt = S_WALK;
      end
      S_ERD: begin
        cmd.erd   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = sts.emit_last ? S_IDLE : S_ERD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: design/gap_dp.sv
module gap_dp #(
  parameter int GRID_COLS = gap_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = gap_pkg::GRID_ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gap_pkg::gap_cmd_t cmd,
  output gap_pkg::gap_sts_t sts,
  input  logic              in_operation,
  input  logic [2:0]        in_cell_col,
  input  logic [2:0]        in_cell_row,
  input  logic              in_cell_wall,
  input  logic [2:0]        in_start_col,
  input  logic [2:0]        in_start_row,
  input  logic [2:0]        in_goal_col,
  input  logic [2:0]        in_goal_row,
  output logic              out_valid,
  output logic [2:0]        out_step_col,
  output logic [2:0]        out_step_row,
  output logic              out_found,
  output logic              out_empty_path,
  output logic              out_last
);

  localparam int N  = GRID_COLS * GRID_ROWS;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(GRID_COLS);
  localparam int RW = $clog2(GRID_ROWS);
  localparam int DW = $clog2(N + GRID_COLS + GRID_ROWS + 1);
  localparam int LW = IW + 1;
  localparam int JW = $clog2(gap_pkg::MAX_RESULTS + 1);
  localparam int PW = RW + CW;

  function automatic logic [IW-1:0] cidx(input logic [CW-1:0] c, input logic [RW-1:0] r);
    cidx = IW'(int'(r) * GRID_COLS + int'(c));
  endfunction

  function automatic logic [DW-1:0] manh(input logic [CW-1:0] c, input logic [RW-1:0] r,
                                         input logic [CW-1:0] c2, input logic [RW-1:0] r2);
    logic [CW-1:0] dc;
    logic [RW-1:0] dr;
    dc   = (c > c2) ? c - c2 : c2 - c;
    dr   = (r > r2) ? r - r2 : r2 - r;
    manh = DW'(dc) + DW'(dr);
  endfunction

  function automatic logic [2:0] col3(input logic [CW-1:0] c);
    logic [CW+2:0] t;
    t    = {3'b000, c};
    col3 = t[2:0];
  endfunction

  function automatic logic [2:0] row3(input logic [RW-1:0] r);
    logic [RW+2:0] t;
    t    = {3'b000, r};
    row3 = t[2:0];
  endfunction

  // per-cell flags
  logic [N-1:0] wall_r, open_r, closed_r, costv_r;

  // per-cell stores, read data registered
  logic [DW-1:0] cost_mem [N];
  logic [DW-1:0] est_mem  [N];
  logic [PW-1:0] par_mem  [N];
  logic [PW-1:0] trail_mem[N];
  logic [DW-1:0] cost_rd, est_rd;
  logic [PW-1:0] par_rd, trail_rd;

  logic [CW-1:0] sc_r, gc_r;
  logic [RW-1:0] sr_r, gr_r;
  logic [IW-1:0] sidx, gidx;

  // scan
  logic [IW-1:0] si_r;
  logic [CW-1:0] scol_r;
  logic [RW-1:0] srow_r;
  logic          v1_r, open1_r;
  logic [IW-1:0] idx1_r;
  logic [CW-1:0] col1_r;
  logic [RW-1:0] row1_r;
  logic [DW-1:0] best_r;
  logic          any_r;
  logic [IW-1:0] cur_r;
  logic [CW-1:0] cc_r;
  logic [RW-1:0] cr_r;

  // expansion
  logic [DW-1:0] curcost_r, tent;
  logic [1:0]    dir_r;
  logic [CW-1:0] nc, ncr_r;
  logic [RW-1:0] nr, nrr_r;
  logic          inb, nb_ok, upd;
  logic [IW-1:0] nidx, n_r, cost_ra;

  // walk and emit
  logic [CW-1:0] wc_r;
  logic [RW-1:0] wr_r;
  logic [IW-1:0] widx, ta;
  logic [LW-1:0] len_r;
  logic [JW-1:0] j_r, total;
  logic          has_par, emit_last;

  logic          out_valid_r, out_found_r, out_empty_r, out_last_r;
  logic [2:0]    out_col_r, out_row_r;
  logic          wr_in_grid;

  assign sidx = cidx(sc_r, sr_r);
  assign gidx = cidx(gc_r, gr_r);
  assign widx = cidx(wc_r, wr_r);

  always_comb begin
    nc  = cc_r;
    nr  = cr_r;
    inb = 1'b0;
    case (dir_r)
      2'd0: begin inb = (cc_r != '0); nc = cc_r - CW'(1); end
      2'd1: begin inb = (int'(cc_r) + 1 < GRID_COLS); nc = cc_r + CW'(1); end
      2'd2: begin inb = (cr_r != '0); nr = cr_r - RW'(1); end
      2'd3: begin inb = (int'(cr_r) + 1 < GRID_ROWS); nr = cr_r + RW'(1); end
      default: inb = 1'b0;
    endcase
  end

  assign nidx    = cidx(nc, nr);
  assign nb_ok   = inb && !wall_r[nidx] && !closed_r[nidx];
  assign cost_ra = cmd.nb ? nidx : cur_r;
  assign tent    = curcost_r + DW'(1);
  assign upd     = !costv_r[n_r] || (tent < cost_rd);
  assign has_par = costv_r[widx] && (widx != sidx);
  assign total   = (int'(len_r) > gap_pkg::MAX_RESULTS) ?
                   JW'(gap_pkg::MAX_RESULTS) : JW'(len_r);
  assign emit_last = ((j_r + JW'(1)) == total);
  assign ta      = IW'(int'(len_r) - 1 - int'(j_r));
  assign wr_in_grid = (int'(in_cell_col) < GRID_COLS) && (int'(in_cell_row) < GRID_ROWS);

  always_comb begin
    sts           = '0;
    sts.is_search = in_operation;
    sts.in_bad    = (int'(in_start_col) >= GRID_COLS) || (int'(in_start_row) >= GRID_ROWS) ||
                    (int'(in_goal_col) >= GRID_COLS) || (int'(in_goal_row) >= GRID_ROWS);
    sts.in_same   = (in_start_col == in_goal_col) && (in_start_row == in_goal_row);
    sts.scan_last = (si_r == IW'(N - 1));
    sts.any       = any_r;
    sts.cur_goal  = (cur_r == gidx);
    sts.nb_ok     = nb_ok;
    sts.dir_last  = (dir_r == 2'd3);
    sts.has_par   = has_par;
    sts.emit_last = emit_last;
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      cost_mem[sidx] <= '0;
      est_mem[sidx]  <= manh(sc_r, sr_r, gc_r, gr_r);
    end else if (cmd.nbu && upd) begin
      cost_mem[n_r] <= tent;
      est_mem[n_r]  <= tent + manh(ncr_r, nrr_r, gc_r, gr_r);
      par_mem[n_r]  <= {cr_r, cc_r};
    end
    if (cmd.walk && has_par) trail_mem[len_r[IW-1:0]] <= {wr_r, wc_r};
    cost_rd  <= cost_mem[cost_ra];
    est_rd   <= est_mem[si_r];
    par_rd   <= par_mem[widx];
    trail_rd <= trail_mem[ta];
  end

  // flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_r   <= '0;
      open_r   <= '0;
      closed_r <= '0;
      costv_r  <= '0;
    end else begin
      if (cmd.accept && !in_operation && wr_in_grid)
        wall_r[cidx(CW'(in_cell_col), RW'(in_cell_row))] <= in_cell_wall;
      if (cmd.init) begin
        open_r         <= '0;
        closed_r       <= '0;
        costv_r        <= '0;
        open_r[sidx]   <= 1'b1;
        costv_r[sidx]  <= 1'b1;
      end
      if (cmd.exp) begin
        open_r[cur_r]   <= 1'b0;
        closed_r[cur_r] <= 1'b1;
      end
      if (cmd.nb && nb_ok) open_r[nidx] <= 1'b1;
      if (cmd.nbu && upd)  costv_r[n_r] <= 1'b1;
    end
  end

  // search registers
  always_ff @(posedge clk) begin
    if (cmd.accept && in_operation) begin
      sc_r <= CW'(in_start_col);
      sr_r <= RW'(in_start_row);
      gc_r <= CW'(in_goal_col);
      gr_r <= RW'(in_goal_row);
    end
    v1_r <= cmd.scan;
    if (cmd.scan_clr) begin
      si_r   <= '0;
      scol_r <= '0;
      srow_r <= '0;
      best_r <= '1;
      any_r  <= 1'b0;
    end else begin
      if (cmd.scan) begin
        idx1_r  <= si_r;
        col1_r  <= scol_r;
        row1_r  <= srow_r;
        open1_r <= open_r[si_r];
        si_r    <= si_r + IW'(1);
        if (scol_r == CW'(GRID_COLS - 1)) begin
          scol_r <= '0;
          srow_r <= srow_r + RW'(1);
        end else begin
          scol_r <= scol_r + CW'(1);
        end
      end
      // strict compare keeps the lowest index on ties
      if (v1_r && open1_r && (est_rd < best_r)) begin
        best_r <= est_rd;
        any_r  <= 1'b1;
        cur_r  <= idx1_r;
        cc_r   <= col1_r;
        cr_r   <= row1_r;
      end
    end
    if (cmd.exp2) begin
      curcost_r <= cost_rd;
      dir_r     <= 2'd0;
    end
    if (cmd.nb) begin
      if (nb_ok) begin
        n_r   <= nidx;
        ncr_r <= nc;
        nrr_r <= nr;
      end else begin
        dir_r <= dir_r + 2'd1;
      end
    end
    if (cmd.nbu) dir_r <= dir_r + 2'd1;
    if (cmd.walk_init) begin
      wc_r  <= gc_r;
      wr_r  <= gr_r;
      len_r <= '0;
      j_r   <= '0;
    end
    if (cmd.walk && has_par) len_r <= len_r + LW'(1);
    if (cmd.walk2) {wr_r, wc_r} <= par_rd;
    if (cmd.emit) j_r <= j_r + JW'(1);
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.accept && (!in_operation || sts.in_bad || sts.in_same)) ||
                     cmd.out_none || cmd.emit;
    end
    if (cmd.accept) begin
      if (!in_operation) begin
        out_col_r <= in_cell_col;
        out_row_r <= in_cell_row;
        out_found_r <= 1'b0;
        out_empty_r <= 1'b0;
      end else if (sts.in_bad) begin
        out_col_r <= '0;
        out_row_r <= '0;
        out_found_r <= 1'b0;
        out_empty_r <= 1'b0;
      end else begin
        out_col_r <= in_goal_col;
        out_row_r <= in_goal_row;
        out_found_r <= 1'b1;
        out_empty_r <= 1'b1;
      end
      out_last_r <= 1'b1;
    end else if (cmd.out_none) begin
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_found_r <= 1'b0;
      out_empty_r <= 1'b0;
      out_last_r  <= 1'b1;
    end else if (cmd.emit) begin
      out_col_r   <= col3(trail_rd[CW-1:0]);
      out_row_r   <= row3(trail_rd[PW-1:CW]);
      out_found_r <= 1'b1;
      out_empty_r <= 1'b0;
      out_last_r  <= emit_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_step_col   = out_col_r;
  assign out_step_row   = out_row_r;
  assign out_found      = out_found_r;
  assign out_empty_path = out_empty_r;
  assign out_last       = out_last_r;

endmodule

// File: tb/grid_astar_path_search_test.sv
module grid_astar_path_search_test;

  localparam int COLS = gap_pkg::GRID_COLS_DEF;
  localparam int ROWS = gap_pkg::GRID_ROWS_DEF;
  localparam int CELLS = COLS * ROWS;
  localparam int INF_COST = 32'h7fffff;
  localparam int IDLE_LIMIT = 40000;

  typedef enum logic {OP_WRITE = 1'b0, OP_SEARCH = 1'b1} op_t;

  typedef struct {
    op_t      op;
    bit [2:0] cell_col, cell_row;
    bit       cell_wall;
    bit [2:0] start_col, start_row, goal_col, goal_row;
    bit       drain_first;   // hold until every expected step has arrived
  } grid_item_t;

  typedef struct {
    bit [2:0] col, row;
    bit       found, empty_path, last;
  } step_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_operation = 1'b0;
  logic [2:0] in_cell_col = '0, in_cell_row = '0;
  logic       in_cell_wall = 1'b0;
  logic [2:0] in_start_col = '0, in_start_row = '0;
  logic [2:0] in_goal_col = '0, in_goal_row = '0;
  logic       out_valid;
  logic [2:0] out_step_col, out_step_row;
  logic       out_found, out_empty_path, out_last;

  grid_astar_path_search uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_cell_col(in_cell_col), .in_cell_row(in_cell_row),
    .in_cell_wall(in_cell_wall), .in_start_col(in_start_col),
    .in_start_row(in_start_row), .in_goal_col(in_goal_col), .in_goal_row(in_goal_row),
    .out_valid(out_valid), .out_step_col(out_step_col), .out_step_row(out_step_row),
    .out_found(out_found), .out_empty_path(out_empty_path), .out_last(out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  grid_item_t pending_items[$];
  step_t      expected_steps[$];
  grid_item_t cur_item;
  int         fail_count = 0;
  int         items_sent = 0;
  bit         took = 1'b0;

  // Local copy of the wall map and the search scratch stores.
  bit wall_map[CELLS];
  int g_cost[CELLS], f_est[CELLS], parent[CELLS];
  bit open_set[CELLS], closed_set[CELLS], has_par[CELLS];

  function automatic int mdist(int a, int b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic void push_step(int c, int r, bit f, bit e, bit l);
    step_t s;
    s.col = c[2:0]; s.row = r[2:0]; s.found = f; s.empty_path = e; s.last = l;
    expected_steps = {expected_steps, s};
  endfunction

  function automatic void add_item(grid_item_t it);
    pending_items = {pending_items, it};
  endfunction

  // Run A* on the local map and queue the path steps it yields.
  function automatic void predict_path(int sc, int sr, int gc, int gr);
    int s, g, cur, best, nc, nr, n, tent, cnt;
    bit any;
    int trail[$];
    if (sc >= COLS || sr >= ROWS || gc >= COLS || gr >= ROWS) begin
      push_step(0, 0, 0, 0, 1);
      return;
    end
    s = sr * COLS + sc;
    g = gr * COLS + gc;
    if (s == g) begin
      push_step(gc, gr, 1, 1, 1);
      return;
    end
    for (int i = 0; i < CELLS; i++) begin
      g_cost[i] = INF_COST; f_est[i] = 0;
      open_set[i] = 0; closed_set[i] = 0; has_par[i] = 0;
    end
    g_cost[s] = 0;
    f_est[s] = mdist(sc, gc) + mdist(sr, gr);
    open_set[s] = 1;
    forever begin
      best = INF_COST; any = 0; cur = 0;
      // strict less keeps the lowest index on a tie
      for (int i = 0; i < CELLS; i++)
        if (open_set[i] && f_est[i] < best) begin
          best = f_est[i]; cur = i; any = 1;
        end
      if (!any) begin
        push_step(0, 0, 0, 0, 1);
        return;
      end
      if (cur == g) break;
      open_set[cur] = 0;
      closed_set[cur] = 1;
      for (int d = 0; d < 4; d++) begin
        nc = cur % COLS; nr = cur / COLS;
        case (d)
          0: begin if (nc == 0) continue; nc--; end
          1: begin if (nc + 1 >= COLS) continue; nc++; end
          2: begin if (nr == 0) continue; nr--; end
          default: begin if (nr + 1 >= ROWS) continue; nr++; end
        endcase
        n = nr * COLS + nc;
        if (wall_map[n] || closed_set[n]) continue;
        tent = g_cost[cur] + 1;
        open_set[n] = 1;
        if (tent >= g_cost[n]) continue;
        parent[n] = cur; has_par[n] = 1; g_cost[n] = tent;
        f_est[n] = tent + mdist(nc, gc) + mdist(nr, gr);
      end
    end
    cur = g;
    cnt = 0;
    while (has_par[cur] && cnt < CELLS) begin
      trail = {cur, trail};
      cur = parent[cur];
      cnt++;
    end
    if (trail.size() > gap_pkg::MAX_RESULTS) trail = trail[0:gap_pkg::MAX_RESULTS-1];
    foreach (trail[j])
      push_step(trail[j] % COLS, trail[j] / COLS, 1, 0, j == trail.size() - 1);
  endfunction

  function automatic void predict_item(grid_item_t it);
    if (it.op == OP_WRITE) begin
      wall_map[it.cell_row * COLS + it.cell_col] = it.cell_wall;
      push_step(it.cell_col, it.cell_row, 0, 0, 1);
    end else begin
      predict_path(it.start_col, it.start_row, it.goal_col, it.goal_row);
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Predict on acceptance, then check whatever the block shows this cycle.
  always @(posedge clk) begin
    step_t e;
    took <= start && !busy && rst_n;
    if (rst_n && start && !busy) predict_item(cur_item);
    if (rst_n && out_valid) begin
      if (expected_steps.size() == 0) begin
        report_mismatch("unexpected step, queue depth", 1, 0);
      end else begin
        e = expected_steps.pop_front();
        if (out_step_col !== e.col) report_mismatch("step_col", out_step_col, e.col);
        if (out_step_row !== e.row) report_mismatch("step_row", out_step_row, e.row);
        if (out_found !== e.found) report_mismatch("found", out_found, e.found);
        if (out_empty_path !== e.empty_path)
          report_mismatch("empty_path", out_empty_path, e.empty_path);
        if (out_last !== e.last) report_mismatch("last", out_last, e.last);
      end
    end
  end

  // Drive at the falling edge; one update of start per step.
  int gap_left = 0;
  always @(negedge clk) begin
    bit start_n;
    if (rst_n) begin
      start_n = start;
      if (start && took) begin
        start_n = 1'b0;
        items_sent++;
        // alternate between bursts with no idling and random gaps
        gap_left = ((items_sent / 16) % 2) ? 0 : $urandom_range(0, 12);
      end
      if (!start_n) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0 &&
                     (!pending_items[0].drain_first ||
                      (expected_steps.size() == 0 && !busy))) begin
          cur_item = pending_items.pop_front();
          in_operation <= cur_item.op;
          in_cell_col <= cur_item.cell_col;
          in_cell_row <= cur_item.cell_row;
          in_cell_wall <= cur_item.cell_wall;
          in_start_col <= cur_item.start_col;
          in_start_row <= cur_item.start_row;
          in_goal_col <= cur_item.goal_col;
          in_goal_row <= cur_item.goal_row;
          start_n = 1'b1;
        end
      end
      start <= start_n;
    end
  end

  // Abort when nothing moves for too long.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic grid_item_t wr(int c, int r, bit w);
    grid_item_t it;
    it = '{op: OP_WRITE, default: '0};
    it.cell_col = 3'(c); it.cell_row = 3'(r); it.cell_wall = w;
    it.start_col = 3'($urandom); it.start_row = 3'($urandom);
    it.goal_col = 3'($urandom); it.goal_row = 3'($urandom);
    return it;
  endfunction

  function automatic grid_item_t sr(int a, int b, int c, int d);
    grid_item_t it;
    it = '{op: OP_SEARCH, default: '0};
    it.start_col = 3'(a); it.start_row = 3'(b);
    it.goal_col = 3'(c); it.goal_row = 3'(d);
    it.cell_col = 3'($urandom); it.cell_row = 3'($urandom);
    it.cell_wall = 1'($urandom);
    return it;
  endfunction

  initial begin
    grid_item_t it;
    foreach (wall_map[i]) wall_map[i] = 0;
    // directed: corners, start equals goal, walls on start and goal, no path
    add_item(sr(0, 0, 7, 7));
    add_item(sr(7, 7, 0, 0));
    add_item(sr(4, 4, 4, 4));
    add_item(wr(0, 0, 1));
    add_item(wr(7, 7, 1));
    add_item(sr(7, 7, 7, 7));        // same cell, even on a wall
    add_item(sr(0, 0, 5, 3));        // start on a wall
    add_item(sr(2, 2, 7, 7));        // goal is a wall
    for (int r = 0; r < 7; r++) add_item(wr(3, r, 1));
    add_item(sr(1, 0, 6, 0));        // detour around the column
    add_item(wr(3, 7, 1));
    add_item(sr(1, 1, 6, 6));        // walled off
    add_item(sr(5, 2, 6, 5));        // ties between open cells
    it = sr(1, 2, 2, 1);
    it.drain_first = 1;
    add_item(it);
    for (int r = 0; r < 8; r++) add_item(wr(3, r, 0));
    add_item(wr(0, 0, 0));
    // random: sparse maps with many searches
    for (int n = 0; n < 110; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: it = wr($urandom, $urandom, $urandom_range(0, 3) != 0);
        4: it = wr($urandom, $urandom, 0);
        5: it = sr($urandom, $urandom, $urandom, $urandom);
        default: begin
          it = sr($urandom, $urandom, $urandom, $urandom);
          if ($urandom_range(0, 5) == 0) begin
            it.goal_col = it.start_col; it.goal_row = it.start_row;
          end
        end
      endcase
      if (n % 37 == 20) it.drain_first = 1;
      add_item(it);
    end
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    wait (pending_items.size() == 0 && !start);
    wait (expected_steps.size() == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// File: sim.f
design/gap_pkg.sv
design/gap_ctrl.sv
design/gap_dp.sv
design/grid_astar_path_search.sv
tb/grid_astar_path_search_test.sv
